// ----- hdl/rcp_pkg.sv -----
// Shared constants and types for the rectangle/circle penetration pipeline.
package rcp_pkg;

    localparam int COORD_WIDTH_DEF = 24;

    typedef enum logic [1:0] {
        MODE_ZERO,
        MODE_EDGE,
        MODE_CORNER
    } t_mode;

    typedef enum logic [1:0] {
        EDGE_TOP,
        EDGE_RIGHT,
        EDGE_BOTTOM,
        EDGE_LEFT
    } t_edge;

    typedef enum logic [1:0] {
        CORN_NONE,
        CORN_A,
        CORN_N
    } t_corn;

endpackage

// ----- hdl/rect_circle_penetration_top.sv -----
// Penetration vector of a circle into an axis-aligned rectangle, fully pipelined.
//
//  channel | valid   | stall   | word
//  --------+---------+---------+------------------------------------------------------
//  in      | i_valid | o_stall | i_rect_left/top/right/bottom, i_center_x/y, i_circle_radius
//  out     | o_valid | i_stall | o_push_x, o_push_y
//
// One word enters per cycle while the output is not stalled; the depth of the pipe
// is set by the square root (one root bit per stage) and the two dividers (one
// quotient bit per stage).
// Reset clears only the stage valid bits.
// All stages advance together; a stalled output holds the whole pipe, so
// o_stall is high only while a finished word waits and i_stall is high.
module rect_circle_penetration_top
    import rcp_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [COORD_WIDTH-1:0] i_rect_left,
    input  logic signed [COORD_WIDTH-1:0] i_rect_top,
    input  logic signed [COORD_WIDTH-1:0] i_rect_right,
    input  logic signed [COORD_WIDTH-1:0] i_rect_bottom,
    input  logic signed [COORD_WIDTH-1:0] i_center_x,
    input  logic signed [COORD_WIDTH-1:0] i_center_y,
    input  logic        [COORD_WIDTH-2:0] i_circle_radius,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [COORD_WIDTH-1:0] o_push_x,
    output logic signed [COORD_WIDTH-1:0] o_push_y
);

    localparam int W  = COORD_WIDTH;
    localparam int RW = W - 1;       // radius / corner magnitudes
    localparam int DW = W + 2;       // differences and depths
    localparam int VW = W + 3;       // edge push before saturation
    localparam int PW = 2 * RW;      // squares and products
    localparam int SW = 2 * W - 1;   // sum of squares, dividend
    localparam int QW = W - 1;       // quotient bits

    typedef struct packed {
        t_mode                 mode;
        t_edge                 sel;
        logic signed [VW-1:0]  val;
        logic                  sx;
        logic                  sy;
    } t_side;

    function automatic logic signed [2:0] sgn3(input logic signed [DW-1:0] v);
        logic signed [2:0] s;
        if (v > 0)      s = 3'sd1;
        else if (v < 0) s = -3'sd1;
        else            s = 3'sd0;
        return s;
    endfunction

    function automatic logic signed [W-1:0] sat(input logic signed [VW-1:0] v);
        logic signed [VW-1:0] hi;
        logic signed [VW-1:0] lo;
        logic signed [W-1:0]  y;
        hi = VW'({1'b0, {(W-1){1'b1}}});
        lo = -hi - VW'(1);
        if (v > hi)      y = {1'b0, {(W-1){1'b1}}};
        else if (v < lo) y = {1'b1, {(W-1){1'b0}}};
        else             y = W'(v);
        return y;
    endfunction

    logic en;
    logic r_o_vld;
    assign en      = !r_o_vld || !i_stall;
    assign o_stall = !en;
    assign o_valid = r_o_vld;

    // ---------------- stage 1: input register
    logic                  r1_vld;
    logic signed [W-1:0]   r1_l, r1_t, r1_rt, r1_b, r1_cx, r1_cy;
    logic        [RW-1:0]  r1_rad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (en) begin
            r1_vld <= i_valid;
        end
        if (en) begin
            r1_l   <= i_rect_left;
            r1_t   <= i_rect_top;
            r1_rt  <= i_rect_right;
            r1_b   <= i_rect_bottom;
            r1_cx  <= i_center_x;
            r1_cy  <= i_center_y;
            r1_rad <= i_circle_radius;
        end
    end

    // ---------------- stage 2: differences and edge depths
    logic                  r2_vld;
    logic signed [DW-1:0]  r2_dxl, r2_dxr, r2_dyt, r2_dyb, r2_wx, r2_hy;
    logic signed [DW-1:0]  r2_p0, r2_p1, r2_p2, r2_p3;
    logic        [RW-1:0]  r2_rad;
    logic signed [DW-1:0]  n2_dxl, n2_dxr, n2_dyt, n2_dyb;

    assign n2_dxl = DW'(r1_cx) - DW'(r1_l);
    assign n2_dxr = DW'(r1_cx) - DW'(r1_rt);
    assign n2_dyt = DW'(r1_cy) - DW'(r1_t);
    assign n2_dyb = DW'(r1_cy) - DW'(r1_b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (en) begin
            r2_vld <= r1_vld;
        end
        if (en) begin
            r2_dxl <= n2_dxl;
            r2_dxr <= n2_dxr;
            r2_dyt <= n2_dyt;
            r2_dyb <= n2_dyb;
            r2_wx  <= DW'(r1_rt) - DW'(r1_l);
            r2_hy  <= DW'(r1_b) - DW'(r1_t);
            r2_p0  <= -n2_dyt;
            r2_p1  <= n2_dxr;
            r2_p2  <= n2_dyb;
            r2_p3  <= -n2_dxl;
            r2_rad <= r1_rad;
        end
    end

    // ---------------- stage 3: edge pick and Voronoi region
    logic                  r3_vld;
    logic                  r3_out;
    t_edge                 r3_sel;
    t_corn                 r3_corn;
    logic signed [DW-1:0]  r3_best, r3_dx, r3_dy;
    logic        [RW-1:0]  r3_rad;

    logic                  n3_out;
    t_edge                 n3_sel;
    t_corn                 n3_corn;
    logic signed [DW-1:0]  n3_best, n3_dx, n3_dy;

    always_comb begin
        logic signed [DW-1:0] vxd [4];
        logic signed [DW-1:0] vyd [4];
        logic signed [2:0]    sex, sey, da, dn;
        logic [1:0]           a, n;
        vxd[0] = r2_dxl; vxd[1] = r2_dxr; vxd[2] = r2_dxr; vxd[3] = r2_dxl;
        vyd[0] = r2_dyt; vyd[1] = r2_dyt; vyd[2] = r2_dyb; vyd[3] = r2_dyb;
        n3_out  = 1'b1;
        n3_corn = CORN_NONE;
        if (r2_p0 > 0) begin
            n3_sel = EDGE_TOP;    n3_best = r2_p0;
        end else if (r2_p1 > 0) begin
            n3_sel = EDGE_RIGHT;  n3_best = r2_p1;
        end else if (r2_p2 > 0) begin
            n3_sel = EDGE_BOTTOM; n3_best = r2_p2;
        end else if (r2_p3 > 0) begin
            n3_sel = EDGE_LEFT;   n3_best = r2_p3;
        end else begin
            n3_out  = 1'b0;
            n3_sel  = EDGE_TOP;
            n3_best = r2_p0;
            if (r2_p1 > n3_best) begin
                n3_sel = EDGE_RIGHT;  n3_best = r2_p1;
            end
            if (r2_p2 > n3_best) begin
                n3_sel = EDGE_BOTTOM; n3_best = r2_p2;
            end
            if (r2_p3 > n3_best) begin
                n3_sel = EDGE_LEFT;   n3_best = r2_p3;
            end
        end
        a = n3_sel;
        n = a + 2'd1;
        case (n3_sel)
            EDGE_TOP:    begin sex = sgn3(r2_wx);  sey = 3'sd0;         end
            EDGE_RIGHT:  begin sex = 3'sd0;        sey = sgn3(r2_hy);   end
            EDGE_BOTTOM: begin sex = -sgn3(r2_wx); sey = 3'sd0;         end
            default:     begin sex = 3'sd0;        sey = -sgn3(r2_hy);  end
        endcase
        da = sgn3(vxd[a]) * sex + sgn3(vyd[a]) * sey;
        dn = -(sgn3(vxd[n]) * sex) - sgn3(vyd[n]) * sey;
        if (n3_out && da < 0) begin
            n3_corn = CORN_A;
        end else if (n3_out && dn < 0) begin
            n3_corn = CORN_N;
        end
        n3_dx = (n3_corn == CORN_N) ? vxd[n] : vxd[a];
        n3_dy = (n3_corn == CORN_N) ? vyd[n] : vyd[a];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (en) begin
            r3_vld <= r2_vld;
        end
        if (en) begin
            r3_out  <= n3_out;
            r3_sel  <= n3_sel;
            r3_corn <= n3_corn;
            r3_best <= n3_best;
            r3_dx   <= n3_dx;
            r3_dy   <= n3_dy;
            r3_rad  <= r2_rad;
        end
    end

    // ---------------- stage 4: mode and magnitudes
    logic                  r4_vld;
    t_side                 r4_side;
    logic        [RW-1:0]  r4_ax, r4_ay, r4_rad;
    t_side                 n4_side;
    logic        [DW-1:0]  n4_ax, n4_ay;

    always_comb begin
        logic signed [DW-1:0] rad_s;
        rad_s = $signed(DW'(r3_rad));
        n4_ax = (r3_dx < 0) ? DW'(-r3_dx) : DW'(r3_dx);
        n4_ay = (r3_dy < 0) ? DW'(-r3_dy) : DW'(r3_dy);
        n4_side.sel  = r3_sel;
        n4_side.val  = VW'(rad_s) - VW'(r3_best);
        n4_side.sx   = r3_dx[DW-1];
        n4_side.sy   = r3_dy[DW-1];
        n4_side.mode = MODE_EDGE;
        if (r3_out) begin
            if (r3_corn != CORN_NONE) begin
                if (n4_ax > DW'(r3_rad) || n4_ay > DW'(r3_rad)) begin
                    n4_side.mode = MODE_ZERO;
                end else begin
                    n4_side.mode = MODE_CORNER;
                end
            end else if (r3_best > rad_s) begin
                n4_side.mode = MODE_ZERO;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else if (en) begin
            r4_vld <= r3_vld;
        end
        if (en) begin
            r4_side <= n4_side;
            r4_ax   <= RW'(n4_ax);
            r4_ay   <= RW'(n4_ay);
            r4_rad  <= r3_rad;
        end
    end

    // ---------------- stage 5: squares
    logic                  r5_vld;
    t_side                 r5_side;
    logic        [RW-1:0]  r5_ax, r5_ay, r5_rad;
    logic        [PW-1:0]  r5_sqx, r5_sqy, r5_rr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else if (en) begin
            r5_vld <= r4_vld;
        end
        if (en) begin
            r5_side <= r4_side;
            r5_ax   <= r4_ax;
            r5_ay   <= r4_ay;
            r5_rad  <= r4_rad;
            r5_sqx  <= PW'(r4_ax) * PW'(r4_ax);
            r5_sqy  <= PW'(r4_ay) * PW'(r4_ay);
            r5_rr   <= PW'(r4_rad) * PW'(r4_rad);
        end
    end

    // ---------------- stage 6: squared distance and range check
    logic                  r6_vld;
    t_side                 r6_side;
    logic        [RW-1:0]  r6_ax, r6_ay, r6_rad;
    logic        [SW-1:0]  r6_s;
    logic        [SW-1:0]  n6_s;
    t_side                 n6_side;

    always_comb begin
        n6_s    = SW'(r5_sqx) + SW'(r5_sqy);
        n6_side = r5_side;
        if (r5_side.mode == MODE_CORNER && (n6_s == '0 || n6_s > SW'(r5_rr))) begin
            n6_side.mode = MODE_ZERO;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_vld <= 1'b0;
        end else if (en) begin
            r6_vld <= r5_vld;
        end
        if (en) begin
            r6_side <= n6_side;
            r6_ax   <= r5_ax;
            r6_ay   <= r5_ay;
            r6_rad  <= r5_rad;
            r6_s    <= n6_s;
        end
    end

    // ---------------- square root, one root bit per stage
    logic                  r_sq_vld  [1:W];
    t_side                 r_sq_side [1:W];
    logic        [RW-1:0]  r_sq_ax   [1:W];
    logic        [RW-1:0]  r_sq_ay   [1:W];
    logic        [RW-1:0]  r_sq_rad  [1:W];
    logic        [SW-1:0]  r_sq_rem  [1:W];
    logic        [SW:0]    r_sq_res  [1:W];

    for (genvar j = 0; j < W; j++) begin : g_sqrt
        localparam int K = W - 1 - j;
        logic              vin;
        t_side             sin;
        logic [RW-1:0]     axin, ayin, radin;
        logic [SW-1:0]     remin;
        logic [SW:0]       resin, trial, bitv;

        if (j == 0) begin : g_first
            assign vin   = r6_vld;
            assign sin   = r6_side;
            assign axin  = r6_ax;
            assign ayin  = r6_ay;
            assign radin = r6_rad;
            assign remin = r6_s;
            assign resin = '0;
        end else begin : g_next
            assign vin   = r_sq_vld[j];
            assign sin   = r_sq_side[j];
            assign axin  = r_sq_ax[j];
            assign ayin  = r_sq_ay[j];
            assign radin = r_sq_rad[j];
            assign remin = r_sq_rem[j];
            assign resin = r_sq_res[j];
        end

        assign bitv  = (SW + 1)'(1) << (2 * K);
        assign trial = resin + bitv;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_vld[j+1] <= 1'b0;
            end else if (en) begin
                r_sq_vld[j+1] <= vin;
            end
            if (en) begin
                r_sq_side[j+1] <= sin;
                r_sq_ax[j+1]   <= axin;
                r_sq_ay[j+1]   <= ayin;
                r_sq_rad[j+1]  <= radin;
                if ({1'b0, remin} >= trial) begin
                    r_sq_rem[j+1] <= remin - SW'(trial);
                    r_sq_res[j+1] <= (resin >> 1) + bitv;
                end else begin
                    r_sq_rem[j+1] <= remin;
                    r_sq_res[j+1] <= resin >> 1;
                end
            end
        end
    end

    // ---------------- stage 7: round root to nearest
    logic                  r7_vld;
    t_side                 r7_side;
    logic        [RW-1:0]  r7_ax, r7_ay, r7_rad, r7_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_vld <= 1'b0;
        end else if (en) begin
            r7_vld <= r_sq_vld[W];
        end
        if (en) begin
            r7_side <= r_sq_side[W];
            r7_ax   <= r_sq_ax[W];
            r7_ay   <= r_sq_ay[W];
            r7_rad  <= r_sq_rad[W];
            r7_len  <= RW'(r_sq_res[W]) + RW'({1'b0, r_sq_rem[W]} > r_sq_res[W]);
        end
    end

    // ---------------- stage 8: radius minus distance
    logic                  r8_vld;
    t_side                 r8_side;
    logic        [RW-1:0]  r8_ax, r8_ay, r8_len, r8_m;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r8_vld <= 1'b0;
        end else if (en) begin
            r8_vld <= r7_vld;
        end
        if (en) begin
            r8_side <= r7_side;
            r8_ax   <= r7_ax;
            r8_ay   <= r7_ay;
            r8_len  <= r7_len;
            r8_m    <= r7_rad - r7_len;
        end
    end

    // ---------------- stage 9: scale products
    logic                  r9_vld;
    t_side                 r9_side;
    logic        [RW-1:0]  r9_len;
    logic        [PW-1:0]  r9_px, r9_py;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r9_vld <= 1'b0;
        end else if (en) begin
            r9_vld <= r8_vld;
        end
        if (en) begin
            r9_side <= r8_side;
            r9_len  <= r8_len;
            r9_px   <= PW'(r8_ax) * PW'(r8_m);
            r9_py   <= PW'(r8_ay) * PW'(r8_m);
        end
    end

    // ---------------- stage 10: rounding bias
    logic                  r10_vld;
    t_side                 r10_side;
    logic        [RW-1:0]  r10_len;
    logic        [SW-1:0]  r10_nx, r10_ny;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r10_vld <= 1'b0;
        end else if (en) begin
            r10_vld <= r9_vld;
        end
        if (en) begin
            r10_side <= r9_side;
            r10_len  <= r9_len;
            r10_nx   <= SW'(r9_px) + SW'(r9_len >> 1);
            r10_ny   <= SW'(r9_py) + SW'(r9_len >> 1);
        end
    end

    // ---------------- dividers, one quotient bit per stage
    logic                  r_dv_vld  [1:QW];
    t_side                 r_dv_side [1:QW];
    logic        [RW-1:0]  r_dv_len  [1:QW];
    logic        [SW-1:0]  r_dv_rx   [1:QW];
    logic        [SW-1:0]  r_dv_ry   [1:QW];
    logic        [QW-1:0]  r_dv_qx   [1:QW];
    logic        [QW-1:0]  r_dv_qy   [1:QW];

    for (genvar j = 0; j < QW; j++) begin : g_div
        localparam int K = QW - 1 - j;
        logic              vin;
        t_side             sin;
        logic [RW-1:0]     lenin;
        logic [SW-1:0]     rxin, ryin, dsh;
        logic [QW-1:0]     qxin, qyin, qbit;

        if (j == 0) begin : g_first
            assign vin   = r10_vld;
            assign sin   = r10_side;
            assign lenin = r10_len;
            assign rxin  = r10_nx;
            assign ryin  = r10_ny;
            assign qxin  = '0;
            assign qyin  = '0;
        end else begin : g_next
            assign vin   = r_dv_vld[j];
            assign sin   = r_dv_side[j];
            assign lenin = r_dv_len[j];
            assign rxin  = r_dv_rx[j];
            assign ryin  = r_dv_ry[j];
            assign qxin  = r_dv_qx[j];
            assign qyin  = r_dv_qy[j];
        end

        assign dsh  = SW'(lenin) << K;
        assign qbit = QW'(1) << K;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_vld[j+1] <= 1'b0;
            end else if (en) begin
                r_dv_vld[j+1] <= vin;
            end
            if (en) begin
                r_dv_side[j+1] <= sin;
                r_dv_len[j+1]  <= lenin;
                if (rxin >= dsh) begin
                    r_dv_rx[j+1] <= rxin - dsh;
                    r_dv_qx[j+1] <= qxin | qbit;
                end else begin
                    r_dv_rx[j+1] <= rxin;
                    r_dv_qx[j+1] <= qxin;
                end
                if (ryin >= dsh) begin
                    r_dv_ry[j+1] <= ryin - dsh;
                    r_dv_qy[j+1] <= qyin | qbit;
                end else begin
                    r_dv_ry[j+1] <= ryin;
                    r_dv_qy[j+1] <= qyin;
                end
            end
        end
    end

    // ---------------- output stage: sign, edge normal, saturation
    logic signed [W-1:0]   r_px, r_py;
    logic signed [W-1:0]   n_px, n_py;

    always_comb begin
        t_side               sd;
        logic signed [W-1:0] qx, qy, ev, evn;
        sd  = r_dv_side[QW];
        qx  = $signed(W'(r_dv_qx[QW]));
        qy  = $signed(W'(r_dv_qy[QW]));
        ev  = sat(sd.val);
        evn = sat(-sd.val);
        n_px = '0;
        n_py = '0;
        case (sd.mode)
            MODE_CORNER: begin
                n_px = sd.sx ? -qx : qx;
                n_py = sd.sy ? -qy : qy;
            end
            MODE_EDGE: begin
                case (sd.sel)
                    EDGE_TOP:    n_py = evn;
                    EDGE_RIGHT:  n_px = ev;
                    EDGE_BOTTOM: n_py = ev;
                    default:     n_px = evn;
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (en) begin
            r_o_vld <= r_dv_vld[QW];
        end
        if (en) begin
            r_px <= n_px;
            r_py <= n_py;
        end
    end

    assign o_push_x = r_px;
    assign o_push_y = r_py;

endmodule

// ----- tb/sv/tb_rect_circle_penetration_top.sv -----
// Self-checking testbench for the rectangle/circle penetration pipeline.
`timescale 1ns / 100ps

module tb_rect_circle_penetration_top;
    import rcp_pkg::*;

    localparam int CW        = 24;
    localparam int LATENCY   = 2 * CW + 10;
    localparam int N_RANDOM  = 700;
    localparam int CYC_LIMIT = 400000;
    localparam int MAXP      = (1 << (CW - 1)) - 1;
    localparam int MINN      = -(1 << (CW - 1));
    localparam int PAIR_W    = 7 * CW - 1;

    typedef struct packed {
        logic signed [CW-1:0] left;
        logic signed [CW-1:0] top;
        logic signed [CW-1:0] right;
        logic signed [CW-1:0] bottom;
        logic signed [CW-1:0] cx;
        logic signed [CW-1:0] cy;
        logic        [CW-2:0] radius;
    } t_pair;

    typedef struct packed {
        logic signed [CW-1:0] px;
        logic signed [CW-1:0] py;
    } t_push;

    typedef struct {
        t_pair pair;
        logic  known;
        t_push push;
    } t_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    logic signed [CW-1:0] i_rect_left = '0;
    logic signed [CW-1:0] i_rect_top = '0;
    logic signed [CW-1:0] i_rect_right = '0;
    logic signed [CW-1:0] i_rect_bottom = '0;
    logic signed [CW-1:0] i_center_x = '0;
    logic signed [CW-1:0] i_center_y = '0;
    logic        [CW-2:0] i_circle_radius = '0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    logic signed [CW-1:0] o_push_x;
    logic signed [CW-1:0] o_push_y;

    rect_circle_penetration_top #(.COORD_WIDTH(CW)) dut (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    t_push pending_push[$];
    int    mismatches = 0;
    int    cycles = 0;
    bit    stall_off = 1'b0;

    function automatic longint sat_coord(longint v);
        if (v > MAXP) return MAXP;
        if (v < MINN) return MINN;
        return v;
    endfunction

    function automatic int sgn(longint v);
        return (v > 0) - (v < 0);
    endfunction

    function automatic longint round_scale(longint d, longint m, longint len);
        longint mag, q;
        mag = (d < 0) ? -d : d;
        q = (mag * m + len / 2) / len;
        return (d < 0) ? -q : q;
    endfunction

    function automatic void corner_out(longint dx, longint dy, longint r,
                                       output longint px, output longint py);
        longint ax, ay, s, len;
        px = 0;
        py = 0;
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        if (ax > r || ay > r) return;
        s = ax * ax + ay * ay;
        if (s == 0 || s > r * r) return;
        len = 0;
        for (int b = 24; b >= 0; b--)
            if ((len + (longint'(1) << b)) * (len + (longint'(1) << b)) <= s)
                len += longint'(1) << b;
        if (s - len * len > len) len++;
        px = round_scale(dx, r - len, len);
        py = round_scale(dy, r - len, len);
    endfunction

    function automatic t_push predict_push(t_pair p);
        longint vx[4], vy[4], nx[4], ny[4];
        longint cx, cy, r, best, px, py, d;
        int     sel, a, n, da, dn;
        bit     outside;
        t_push  res;
        nx = '{0, 1, 0, -1};
        ny = '{-1, 0, 1, 0};
        cx = p.cx;
        cy = p.cy;
        r = p.radius;
        vx = '{p.left, p.right, p.right, p.left};
        vy = '{p.top, p.top, p.bottom, p.bottom};
        best = 0;
        sel = 0;
        outside = 1'b0;
        px = 0;
        py = 0;
        for (int i = 0; i < 4; i++) begin
            d = (cx - vx[i]) * nx[i] + (cy - vy[i]) * ny[i];
            if (d > 0) begin
                best = d;
                sel = i;
                outside = 1'b1;
                break;
            end
            if (i == 0 || d > best) begin
                best = d;
                sel = i;
            end
        end
        if (outside) begin
            a = sel;
            n = (sel + 1) % 4;
            da = sgn(cx - vx[a]) * sgn(vx[n] - vx[a]) + sgn(cy - vy[a]) * sgn(vy[n] - vy[a]);
            dn = sgn(cx - vx[n]) * sgn(vx[a] - vx[n]) + sgn(cy - vy[n]) * sgn(vy[a] - vy[n]);
            if (da < 0)
                corner_out(cx - vx[a], cy - vy[a], r, px, py);
            else if (dn < 0)
                corner_out(cx - vx[n], cy - vy[n], r, px, py);
            else if (best <= r) begin
                px = nx[sel] * (r - best);
                py = ny[sel] * (r - best);
            end
        end else begin
            px = nx[sel] * (r - best);
            py = ny[sel] * (r - best);
        end
        res.px = CW'(sat_coord(px));
        res.py = CW'(sat_coord(py));
        return res;
    endfunction

    function automatic t_pair mk_pair(int l, int t, int rr, int b, int x, int y, int rad);
        t_pair p;
        p.left = CW'(l); p.top = CW'(t); p.right = CW'(rr); p.bottom = CW'(b);
        p.cx = CW'(x); p.cy = CW'(y); p.radius = (CW-1)'(rad);
        return p;
    endfunction

    function automatic t_push mk_push(int x, int y);
        t_push q;
        q.px = CW'(x);
        q.py = CW'(y);
        return q;
    endfunction

    function automatic int rnd_coord();
        case ($urandom_range(0, 9))
            0: return $urandom;  // full range, truncated to width
            1: return $urandom_range(0, 1) ? MAXP : MINN;
            default: return $signed($urandom_range(0, 8000)) - 4000;
        endcase
    endfunction

    function automatic t_pair rnd_pair();
        t_pair p;
        int    l, t, w, h;
        if ($urandom_range(0, 9) == 0) begin
            p = PAIR_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                         $urandom});
            return p;
        end
        l = $signed($urandom_range(0, 4000)) - 2000;
        t = $signed($urandom_range(0, 4000)) - 2000;
        w = ($urandom_range(0, 15) == 0) ? -$signed($urandom_range(0, 50)) : $urandom_range(0, 800);
        h = ($urandom_range(0, 15) == 0) ? -$signed($urandom_range(0, 50)) : $urandom_range(0, 800);
        p.left = CW'(l); p.top = CW'(t); p.right = CW'(l + w); p.bottom = CW'(t + h);
        p.cx = CW'(l + $signed($urandom_range(0, w + 1200)) - 600);
        p.cy = CW'(t + $signed($urandom_range(0, h + 1200)) - 600);
        if ($urandom_range(0, 7) == 0) p.cx = CW'(rnd_coord());
        if ($urandom_range(0, 7) == 0) p.cy = CW'(rnd_coord());
        case ($urandom_range(0, 7))
            0: p.radius = (CW-1)'($urandom);
            1: p.radius = (CW-1)'(MAXP);
            default: p.radius = (CW-1)'($urandom_range(0, 700));
        endcase
        return p;
    endfunction

    function automatic int gap_len();
        if ($urandom_range(0, 2) != 0) return 0;
        return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
    endfunction

    task automatic send_word(t_pair p);
        i_valid <= 1'b1;
        {i_rect_left, i_rect_top, i_rect_right, i_rect_bottom,
         i_center_x, i_center_y, i_circle_radius} <= p;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pending_push.push_back(predict_push(p));
    endtask

    task automatic idle_cycles(int n);
        if (n > 0) begin
            i_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // result side: random stalls, with a stall-free stretch
    int stall_left = 0;
    always @(posedge i_clk) begin
        t_push want;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (pending_push.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected word: x=%0d y=%0d", o_push_x, o_push_y);
                end else begin
                    want = pending_push.pop_front();
                    if (o_push_x !== want.px || o_push_y !== want.py) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("push mismatch: exp (%0d,%0d) got (%0d,%0d)",
                                     want.px, want.py, o_push_x, o_push_y);
                    end
                end
            end
            if (stall_off) i_stall <= 1'b0;
            else if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                i_stall <= 1'b1;
            end else begin
                stall_left <= gap_len();
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYC_LIMIT) begin
            $display("tb_rect_circle_penetration_top: FAIL");
            $finish;
        end
    end

    t_row rows[$];

    initial begin
        t_pair p;
        t_push exp_push;
        // known answers: separated, inside saturation, corner exact, edges
        rows.push_back('{mk_pair(0, 0, 1000, 1000, 500, -600, 100), 1'b1, mk_push(0, 0)});
        rows.push_back('{mk_pair(0, 0, 1000, 1000, 500, -50, 100), 1'b1, mk_push(0, -50)});
        rows.push_back('{mk_pair(0, 0, 1000, 1000, 1050, 500, 100), 1'b1, mk_push(50, 0)});
        rows.push_back('{mk_pair(0, 0, 1000, 1000, 500, 1050, 100), 1'b1, mk_push(0, 50)});
        rows.push_back('{mk_pair(0, 0, 1000, 1000, -50, 500, 100), 1'b1, mk_push(-50, 0)});
        rows.push_back('{mk_pair(0, 0, 1000, 1000, 500, -100, 100), 1'b1, mk_push(0, 0)});
        rows.push_back('{mk_pair(0, 0, 1000, 1000, 0, 0, 100), 1'b1, mk_push(0, -100)});
        rows.push_back('{mk_pair(0, 0, 1000, 1000, -30, -40, 100), 1'b1, mk_push(-30, -40)});
        rows.push_back('{mk_pair(0, 0, 1000, 1000, 1030, 1040, 100), 1'b1, mk_push(30, 40)});
        rows.push_back('{mk_pair(0, 0, 0, 0, 0, 0, 0), 1'b1, mk_push(0, 0)});
        rows.push_back('{mk_pair(MINN, MINN, MAXP, MAXP, 0, 0, MAXP), 1'b1, mk_push(MAXP, 0)});
        rows.push_back('{mk_pair(0, 0, 10, 10, 5, 5, MAXP), 1'b1, mk_push(0, MINN)});
        rows.push_back('{mk_pair(MINN, MINN, MAXP, MAXP, MAXP, MAXP, MAXP), 1'b0, '0});
        rows.push_back('{mk_pair(MAXP, MAXP, MINN, MINN, 0, 0, 5), 1'b0, '0});
        rows.push_back('{mk_pair(100, 100, 50, 50, 75, 75, 20), 1'b0, '0});
        rows.push_back('{mk_pair(0, 0, 1000, 1000, 500, 500, 0), 1'b0, '0});
        rows.push_back('{mk_pair(0, 0, 1000, 1000, 1000, 500, 0), 1'b0, '0});
        rows.push_back('{mk_pair(0, 0, 1000, 1000, -7, -3, 100), 1'b0, '0});
        rows.push_back('{mk_pair(MINN, 0, MAXP, 0, 0, MINN, MAXP), 1'b0, '0});
        rows.push_back('{mk_pair(0, 0, 1000, 1000, MAXP, MINN, MAXP), 1'b0, '0});

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[k]) begin
            exp_push = predict_push(rows[k].pair);
            if (rows[k].known && exp_push != rows[k].push) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("directed row %0d: exp (%0d,%0d) predicted (%0d,%0d)", k,
                             rows[k].push.px, rows[k].push.py, exp_push.px, exp_push.py);
            end
            send_word(rows[k].pair);
        end
        idle_cycles(1);

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM / 2) begin
                // drain fully once before continuing
                i_valid <= 1'b0;
                while (pending_push.size() != 0) @(posedge i_clk);
            end
            stall_off = (n >= 100 && n < 180);
            p = rnd_pair();
            send_word(p);
            if (!(n >= 200 && n < 260)) idle_cycles(gap_len());
        end
        i_valid <= 1'b0;
        stall_off = 1'b0;

        while (pending_push.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (mismatches == 0)
            $display("tb_rect_circle_penetration_top: PASS");
        else
            $display("tb_rect_circle_penetration_top: FAIL");
        $finish;
    end

endmodule
